@@ rtl/fmpd_pkg.sv @@
// Shared types, register map and constant tables for the formation follower.
package fmpd_pkg;

    typedef struct packed {
        logic signed [31:0] own_pos_x;
        logic signed [31:0] own_pos_y;
        logic signed [15:0] own_heading;
        logic signed [31:0] lead_pos_x;
        logic signed [31:0] lead_pos_y;
        logic signed [15:0] lead_heading;
        logic               own_pose_valid;
        logic               lead_pose_valid;
    } t_in;

    typedef struct packed {
        logic signed [31:0] linear_speed;
        logic signed [31:0] turn_rate;
    } t_out;

    typedef enum logic [2:0] {
        REG_GAIN_P    = 3'd0,
        REG_GAIN_D    = 3'd1,
        REG_SPEED_LIM = 3'd2,
        REG_TURN_LIM  = 3'd3,
        REG_OFS_FWD   = 3'd4,
        REG_OFS_LAT   = 3'd5
    } t_reg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
    localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

    // Arctangent of 2^-i in Q2.30, truncated.
    function automatic logic signed [34:0] atan_q30(input logic [4:0] idx);
        logic signed [34:0] r;
        begin
            case (idx)
                5'd0:  r = 35'sh03243F6A8;
                5'd1:  r = 35'sh01DAC6705;
                5'd2:  r = 35'sh00FADBAFC;
                5'd3:  r = 35'sh007F56EA6;
                5'd4:  r = 35'sh003FEAB76;
                5'd5:  r = 35'sh001FFD55B;
                5'd6:  r = 35'sh000FFFAAA;
                5'd7:  r = 35'sh0007FFF55;
                5'd8:  r = 35'sh0003FFFEA;
                5'd9:  r = 35'sh0001FFFFD;
                5'd10: r = 35'sh0000FFFFF;
                5'd11: r = 35'sh00007FFFF;
                5'd12: r = 35'sh00003FFFF;
                5'd13: r = 35'sh00001FFFF;
                5'd14: r = 35'sh00000FFFF;
                5'd15: r = 35'sh000007FFF;
                5'd16: r = 35'sh000003FFF;
                5'd17: r = 35'sh000001FFF;
                5'd18: r = 35'sh000000FFF;
                5'd19: r = 35'sh0000007FF;
                5'd20: r = 35'sh0000003FF;
                5'd21: r = 35'sh0000001FF;
                5'd22: r = 35'sh0000000FF;
                5'd23: r = 35'sh00000007F;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [55:0] v);
        logic signed [31:0] r;
        begin
            if (v > 56'sh00_0000_7FFF_FFFF) r = 32'sh7FFF_FFFF;
            else if (v < -56'sh00_0000_8000_0000) r = 32'sh8000_0000;
            else r = v[31:0];
            return r;
        end
    endfunction

    function automatic logic signed [31:0] clamp_mag(input logic signed [37:0] v,
                                                     input logic [30:0] lim);
        logic signed [37:0] l;
        logic signed [31:0] r;
        begin
            l = signed'({7'd0, lim});
            if (v > l) r = signed'({1'b0, lim});
            else if (v < -l) r = -signed'({1'b0, lim});
            else r = v[31:0];
            return r;
        end
    endfunction

endpackage

@@ rtl/formation_pd_follower_top.sv @@
// Formation follower top level: PD leader-follower law with serial MAC and CORDIC.
//
// One input transaction carries both poses and their validity flags. It is taken
// when i_in_valid is high and o_in_stall is low. A transaction with either flag
// clear is consumed while the block stays idle, makes no result and keeps the
// stored errors. Otherwise the block runs a CORDIC on the leader heading, then
// twelve multiply-accumulate passes on a bit-serial multiplier (a load step then
// 32 bits each, one multiplier bit per cycle unless the last pass is held), with
// a second CORDIC on the robot heading between the gain and rotation passes.
// Each CORDIC runs CORDIC_STEPS steps (at most 24). One item is in work at a time,
// so the next transaction can be taken in the same cycle as the result appears.
// The result waits in an output register; the next input is accepted while it
// waits, and a held-off result only holds the last pass until i_out_stall drops.
// Reset loads the register defaults, clears the stored errors and empties the
// output register. The user must write registers over the APB port only while
// idle; the block itself does not enforce this.
module formation_pd_follower_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fmpd_pkg::t_in        i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output fmpd_pkg::t_out       o_out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CSTEPS = (CORDIC_STEPS < fmpd_pkg::ATAN_ENTRIES) ?
                            CORDIC_STEPS : fmpd_pkg::ATAN_ENTRIES;
    localparam logic [4:0] CLAST = 5'(CSTEPS - 1);

    typedef enum logic [1:0] {S_IDLE, S_CORDIC, S_LOAD, S_MAC} t_state;
    typedef enum logic [3:0] {
        OP_TXF, OP_TXL, OP_TYF, OP_TYL, OP_VXP, OP_VXD, OP_VYP, OP_VYD,
        OP_VF, OP_VL, OP_WF, OP_WL
    } t_op;

    t_state r_state;
    t_op    r_op;
    logic [4:0] r_bit;
    logic [4:0] r_ci;
    fmpd_pkg::t_in r_in;

    logic [15:0] r_kp, r_kd;
    logic [30:0] r_slim, r_tlim;
    logic signed [31:0] r_fwd, r_lat;
    logic signed [31:0] r_last_x, r_last_y;

    logic signed [33:0] r_cx, r_cy;
    logic signed [34:0] r_cz;
    logic r_flip;
    logic signed [33:0] r_lc, r_ls, r_rc, r_rs;

    logic signed [67:0] r_ma, r_acc;
    logic [31:0] r_mb;
    logic signed [31:0] r_ex, r_ey, r_vx, r_vy, r_v;
    logic signed [32:0] r_dx, r_dy;

    logic r_out_valid;
    fmpd_pkg::t_out r_out;

    // Configuration port
    logic w_cfg_wr;
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_comb begin
        case (fmpd_pkg::t_reg'(paddr[4:2]))
            fmpd_pkg::REG_GAIN_P:    prdata = {16'd0, r_kp};
            fmpd_pkg::REG_GAIN_D:    prdata = {16'd0, r_kd};
            fmpd_pkg::REG_SPEED_LIM: prdata = {1'b0, r_slim};
            fmpd_pkg::REG_TURN_LIM:  prdata = {1'b0, r_tlim};
            fmpd_pkg::REG_OFS_FWD:   prdata = r_fwd;
            fmpd_pkg::REG_OFS_LAT:   prdata = r_lat;
            default:                 prdata = '0;
        endcase
    end

    // Handshake
    logic w_in_acc, w_out_take;
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_acc    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_take  = r_out_valid & ~i_out_stall;

    // Hold the last pass until the output register is free.
    logic w_last, w_hold, w_out_load;
    assign w_last     = (r_state == S_MAC) && (r_op == OP_WL) && (r_bit == 5'd31);
    assign w_hold     = w_last && r_out_valid && i_out_stall;
    assign w_out_load = w_last && !w_hold;

    // CORDIC step
    logic signed [33:0] w_xs, w_ys, w_nx, w_ny;
    logic signed [34:0] w_nz;
    assign w_xs = r_cx >>> r_ci;
    assign w_ys = r_cy >>> r_ci;
    always_comb begin
        if (r_cz >= 0) begin
            w_nx = r_cx - w_ys;
            w_ny = r_cy + w_xs;
            w_nz = r_cz - fmpd_pkg::atan_q30(r_ci);
        end else begin
            w_nx = r_cx + w_ys;
            w_ny = r_cy - w_xs;
            w_nz = r_cz + fmpd_pkg::atan_q30(r_ci);
        end
    end

    // Heading in Q3.13 to a folded Q2.30 angle.
    logic signed [34:0] w_z0;
    logic w_f0;
    logic signed [15:0] w_head;
    always_comb begin
        w_head = (r_state == S_IDLE) ? i_in_data.lead_heading : r_in.own_heading;
        w_z0   = signed'({{2{w_head[15]}}, w_head, 17'd0});
        w_f0   = 1'b0;
        if (w_z0 > fmpd_pkg::HALF_PI_Q30) begin
            w_z0 = w_z0 - fmpd_pkg::PI_Q30;
            w_f0 = 1'b1;
        end else if (w_z0 < -fmpd_pkg::HALF_PI_Q30) begin
            w_z0 = w_z0 + fmpd_pkg::PI_Q30;
            w_f0 = 1'b1;
        end
    end

    // Operand select for the serial multiplier.
    logic signed [33:0] w_a;
    logic [31:0] w_b;
    always_comb begin
        case (r_op)
            OP_TXF: begin w_a = r_lc;                w_b = r_fwd; end
            OP_TXL: begin w_a = -r_ls;               w_b = r_lat; end
            OP_TYF: begin w_a = r_ls;                w_b = r_fwd; end
            OP_TYL: begin w_a = r_lc;                w_b = r_lat; end
            OP_VXP: begin w_a = 34'(r_ex);           w_b = {16'd0, r_kp}; end
            OP_VXD: begin w_a = 34'(r_dx);           w_b = {16'd0, r_kd}; end
            OP_VYP: begin w_a = 34'(r_ey);           w_b = {16'd0, r_kp}; end
            OP_VYD: begin w_a = 34'(r_dy);           w_b = {16'd0, r_kd}; end
            OP_VF:  begin w_a = r_rc;                w_b = r_vx; end
            OP_VL:  begin w_a = r_rs;                w_b = r_vy; end
            OP_WF:  begin w_a = -r_rs;               w_b = r_vx; end
            OP_WL:  begin w_a = r_rc;                w_b = r_vy; end
            default: begin w_a = '0;                 w_b = '0; end
        endcase
    end

    // The top multiplier bit carries negative weight.
    logic signed [67:0] w_add, w_sum;
    assign w_add = ~r_mb[0] ? 68'sd0 : ((r_bit == 5'd31) ? -r_ma : r_ma);
    assign w_sum = r_acc + w_add;

    // Position error from the finished target sum.
    logic signed [39:0] w_err;
    logic signed [31:0] w_e;
    logic signed [31:0] w_lead, w_own;
    assign w_lead = (r_op == OP_TXL) ? r_in.lead_pos_x : r_in.lead_pos_y;
    assign w_own  = (r_op == OP_TXL) ? r_in.own_pos_x  : r_in.own_pos_y;
    assign w_err  = 40'(w_lead) + 40'(signed'(w_sum[67:30])) - 40'(w_own);
    assign w_e    = fmpd_pkg::sat32(56'(w_err));

    logic signed [31:0] w_vel;
    assign w_vel = fmpd_pkg::sat32(w_sum[67:12]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_TXF;
            r_bit       <= '0;
            r_ci        <= '0;
            r_kp        <= 16'd4915;
            r_kd        <= 16'd1229;
            r_slim      <= 31'd32768;
            r_tlim      <= 31'd65536;
            r_fwd       <= '0;
            r_lat       <= '0;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_cfg_wr) begin
                case (fmpd_pkg::t_reg'(paddr[4:2]))
                    fmpd_pkg::REG_GAIN_P:    r_kp   <= pwdata[15:0];
                    fmpd_pkg::REG_GAIN_D:    r_kd   <= pwdata[15:0];
                    fmpd_pkg::REG_SPEED_LIM: r_slim <= pwdata[30:0];
                    fmpd_pkg::REG_TURN_LIM:  r_tlim <= pwdata[30:0];
                    fmpd_pkg::REG_OFS_FWD:   r_fwd  <= pwdata;
                    fmpd_pkg::REG_OFS_LAT:   r_lat  <= pwdata;
                    default: ;
                endcase
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (w_out_take) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_in <= i_in_data;
                        if (i_in_data.own_pose_valid && i_in_data.lead_pose_valid) begin
                            r_cx    <= fmpd_pkg::CORDIC_GAIN;
                            r_cy    <= '0;
                            r_cz    <= w_z0;
                            r_flip  <= w_f0;
                            r_ci    <= '0;
                            r_op    <= OP_TXF;
                            r_state <= S_CORDIC;
                        end
                    end
                end
                S_CORDIC: begin
                    r_cx <= w_nx;
                    r_cy <= w_ny;
                    r_cz <= w_nz;
                    r_ci <= r_ci + 5'd1;
                    if (r_ci == CLAST) begin
                        if (r_op == OP_TXF) begin
                            r_lc <= r_flip ? -w_nx : w_nx;
                            r_ls <= r_flip ? -w_ny : w_ny;
                        end else begin
                            r_rc <= r_flip ? -w_nx : w_nx;
                            r_rs <= r_flip ? -w_ny : w_ny;
                        end
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_ma  <= 68'(w_a);
                    r_mb  <= w_b;
                    r_bit <= '0;
                    case (r_op)
                        OP_TXF, OP_TYF, OP_VXP, OP_VYP, OP_VF, OP_WF: r_acc <= '0;
                        default: ;
                    endcase
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (!w_hold) begin
                        r_acc <= w_sum;
                        r_ma  <= r_ma <<< 1;
                        r_mb  <= r_mb >> 1;
                        r_bit <= r_bit + 5'd1;
                        if (r_bit == 5'd31) begin
                            r_op    <= (r_op == OP_WL) ? OP_TXF : t_op'(r_op + 4'd1);
                            r_state <= (r_op == OP_VYD) ? S_CORDIC :
                                       ((r_op == OP_WL) ? S_IDLE : S_LOAD);
                            case (r_op)
                                OP_TXL: begin
                                    r_ex     <= w_e;
                                    r_dx     <= 33'(w_e) - 33'(r_last_x);
                                    r_last_x <= w_e;
                                end
                                OP_TYL: begin
                                    r_ey     <= w_e;
                                    r_dy     <= 33'(w_e) - 33'(r_last_y);
                                    r_last_y <= w_e;
                                end
                                OP_VXD: r_vx <= w_vel;
                                OP_VYD: begin
                                    r_vy   <= w_vel;
                                    r_cx   <= fmpd_pkg::CORDIC_GAIN;
                                    r_cy   <= '0;
                                    r_cz   <= w_z0;
                                    r_flip <= w_f0;
                                    r_ci   <= '0;
                                end
                                OP_VL: r_v <= fmpd_pkg::clamp_mag(w_sum[67:30], r_slim);
                                OP_WL: begin
                                    r_out.linear_speed <= r_v;
                                    r_out.turn_rate    <=
                                        fmpd_pkg::clamp_mag(w_sum[67:30], r_tlim);
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_busy_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_in_stall)
        else $error("input accepted while busy");

    a_cordic_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CORDIC) |-> (r_ci <= CLAST))
        else $error("CORDIC step counter overran");

    a_speed_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_out_data.linear_speed <= signed'({1'b0, r_slim})) &&
                         (o_out_data.linear_speed >= -signed'({1'b0, r_slim}))))
        else $error("linear speed beyond limit");

    a_new_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_out_valid)) |-> $past(r_state == S_MAC))
        else $error("result appeared outside the final pass");

endmodule

@@ verif/tb_formation_pd_follower_top.sv @@
// Testbench for the formation follower: directed table and random ticks checked by a predictor or a typed result.
module tb_formation_pd_follower_top;

    localparam int LATENCY_WAIT = 600;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int LONG_HOLD = 3000;
    localparam int ITEMS_PER_PHASE = 150;
    localparam logic [2:0] REG_UNUSED = 3'd6;

    typedef enum int {ROW_PREDICT, ROW_TYPED, ROW_SILENT} t_row_kind;

    typedef struct {
        fmpd_pkg::t_in  tick;
        t_row_kind      kind;
        fmpd_pkg::t_out want;
    } t_row;

    logic           i_clk;
    logic           i_rst_n;
    logic           i_in_valid;
    logic           o_in_stall;
    fmpd_pkg::t_in  i_in_data;
    logic           o_out_valid;
    logic           i_out_stall;
    fmpd_pkg::t_out o_out_data;
    logic           psel;
    logic           penable;
    logic           pwrite;
    logic [4:0]     paddr;
    logic [31:0]    pwdata;
    logic [31:0]    prdata;
    logic           pready;

    formation_pd_follower_top DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // Predictor state and register copies.
    longint kp_gain, kd_gain, lin_limit, ang_limit, ofs_fwd, ofs_lat;
    longint err_x_prev, err_y_prev;
    fmpd_pkg::t_out cmd_expected[$];
    int     fail_count;
    bit     quiet;
    bit     long_hold_req;
    int     idle_cycles;

    longint atan_tab[24] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic longint sat_word(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Rotation-mode CORDIC; headings beyond a quarter turn are folded by pi.
    function automatic void heading_sincos(input logic signed [15:0] hd,
                                           output longint c, output longint s);
        longint z, x, y, xs, ys;
        bit flip;
        z = longint'(hd) * 131072;
        x = 652032874;
        y = 0;
        flip = 1'b0;
        if (z > 64'sd1686629713) begin
            z -= 64'sd3373259426;
            flip = 1'b1;
        end else if (z < -64'sd1686629713) begin
            z += 64'sd3373259426;
            flip = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_tab[i];
            end else begin
                x += ys; y -= xs; z += atan_tab[i];
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    function automatic bit formation_cmd(input fmpd_pkg::t_in t, output fmpd_pkg::t_out r);
        longint lc, ls, rc, rs, tx, ty, ex, ey, dx, dy, vx, vy;
        r = '0;
        if (!t.own_pose_valid || !t.lead_pose_valid) return 1'b0;
        heading_sincos(t.lead_heading, lc, ls);
        tx = longint'(t.lead_pos_x) + ((lc * ofs_fwd - ls * ofs_lat) >>> 30);
        ty = longint'(t.lead_pos_y) + ((ls * ofs_fwd + lc * ofs_lat) >>> 30);
        ex = sat_word(tx - longint'(t.own_pos_x));
        ey = sat_word(ty - longint'(t.own_pos_y));
        dx = ex - err_x_prev;
        dy = ey - err_y_prev;
        err_x_prev = ex;
        err_y_prev = ey;
        vx = sat_word((kp_gain * ex + kd_gain * dx) >>> 12);
        vy = sat_word((kp_gain * ey + kd_gain * dy) >>> 12);
        heading_sincos(t.own_heading, rc, rs);
        r.linear_speed = 32'(clamp_to((rc * vx + rs * vy) >>> 30, lin_limit));
        r.turn_rate = 32'(clamp_to((-rs * vx + rc * vy) >>> 30, ang_limit));
        return 1'b1;
    endfunction

    function automatic fmpd_pkg::t_in make_tick(input int ox, input int oy, input int oh,
                                                input int lx, input int ly, input int lh,
                                                input bit ov, input bit lv);
        fmpd_pkg::t_in t;
        t.own_pos_x = ox; t.own_pos_y = oy; t.own_heading = oh[15:0];
        t.lead_pos_x = lx; t.lead_pos_y = ly; t.lead_heading = lh[15:0];
        t.own_pose_valid = ov; t.lead_pose_valid = lv;
        return t;
    endfunction

    function automatic int near_coord();
        return int'($urandom_range(0, 4194303)) - 2097152;
    endfunction

    function automatic int rand_heading();
        if ($urandom_range(0, 4) == 0) return int'($urandom);
        return int'($urandom_range(0, 51472)) - 25736;
    endfunction

    // Mostly well-formed ticks with the leader near the robot; some full-range noise.
    function automatic fmpd_pkg::t_in random_tick();
        fmpd_pkg::t_in t;
        int ox, oy;
        bit wide;
        wide = ($urandom_range(0, 3) == 0);
        ox = wide ? int'($urandom) : near_coord();
        oy = wide ? int'($urandom) : near_coord();
        t = make_tick(ox, oy, rand_heading(),
                      wide ? int'($urandom) : ox + near_coord(),
                      wide ? int'($urandom) : oy + near_coord(),
                      rand_heading(), 1'b1, 1'b1);
        if ($urandom_range(0, 9) == 0) begin
            t.own_pose_valid = 1'($urandom_range(0, 1));
            t.lead_pose_valid = t.own_pose_valid ? 1'b0 : 1'($urandom_range(0, 1));
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Setup cycle, then the access cycle; the register is written at the following edge.
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            fmpd_pkg::REG_GAIN_P:    kp_gain = longint'(val[15:0]);
            fmpd_pkg::REG_GAIN_D:    kd_gain = longint'(val[15:0]);
            fmpd_pkg::REG_SPEED_LIM: lin_limit = longint'(val[30:0]);
            fmpd_pkg::REG_TURN_LIM:  ang_limit = longint'(val[30:0]);
            fmpd_pkg::REG_OFS_FWD:   ofs_fwd = longint'(signed'(val));
            fmpd_pkg::REG_OFS_LAT:   ofs_lat = longint'(signed'(val));
            default: ;
        endcase
    endtask

    task automatic cfg_read_check(input logic [2:0] idx, input logic [31:0] want);
        paddr <= {idx, 2'b00};
        @(posedge i_clk);
        if (prdata !== want) report_mismatch("register readback", longint'(prdata),
                                             longint'(want));
        if (pready !== 1'b1) report_mismatch("pready", longint'(pready), 1);
    endtask

    task automatic send_tick(input fmpd_pkg::t_in t, input t_row_kind kind,
                             input fmpd_pkg::t_out want);
        int gap;
        fmpd_pkg::t_out r;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= t;
        do @(posedge i_clk); while (o_in_stall);
        if (formation_cmd(t, r))
            cmd_expected.insert(cmd_expected.size(), (kind == ROW_TYPED) ? want : r);
    endtask

    // Sender pause: lets every pending command come out before registers change.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (cmd_expected.size() != 0) @(posedge i_clk);
        repeat (LATENCY_WAIT) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [31:0] kp, input logic [31:0] kd,
                              input logic [31:0] sl, input logic [31:0] tl,
                              input logic [31:0] fw, input logic [31:0] lt);
        cfg_write(fmpd_pkg::REG_GAIN_P, kp);
        cfg_write(fmpd_pkg::REG_GAIN_D, kd);
        cfg_write(fmpd_pkg::REG_SPEED_LIM, sl);
        cfg_write(fmpd_pkg::REG_TURN_LIM, tl);
        cfg_write(fmpd_pkg::REG_OFS_FWD, fw);
        cfg_write(fmpd_pkg::REG_OFS_LAT, lt);
        cfg_read_check(fmpd_pkg::REG_GAIN_P, 32'(kp_gain));
        cfg_read_check(fmpd_pkg::REG_GAIN_D, 32'(kd_gain));
        cfg_read_check(fmpd_pkg::REG_SPEED_LIM, 32'(lin_limit));
        cfg_read_check(fmpd_pkg::REG_TURN_LIM, 32'(ang_limit));
        cfg_read_check(fmpd_pkg::REG_OFS_FWD, 32'(ofs_fwd));
        cfg_read_check(fmpd_pkg::REG_OFS_LAT, 32'(ofs_lat));
    endtask

    // Result checker.
    always @(posedge i_clk) begin
        fmpd_pkg::t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (cmd_expected.size() == 0) begin
                report_mismatch("unexpected command", o_out_data.linear_speed, 0);
            end else begin
                want = cmd_expected.pop_front();
                if (o_out_data.linear_speed !== want.linear_speed)
                    report_mismatch("linear_speed", o_out_data.linear_speed, want.linear_speed);
                if (o_out_data.turn_rate !== want.turn_rate)
                    report_mismatch("turn_rate", o_out_data.turn_rate, want.turn_rate);
            end
        end
    end

    // Receiver side stall pattern, with one long hold on request.
    initial begin
        int n;
        i_out_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            n = quiet ? 0 : $urandom_range(0, 14);
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
            || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("formation_pd_follower_top regression: fail");
                $finish;
            end
        end
    end

    initial begin
        t_row rows[$];
        fmpd_pkg::t_out zero_cmd;
        fmpd_pkg::t_out none;
        logic [31:0] phase_cfg[6][6];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        fail_count = 0; quiet = 1'b0; long_hold_req = 1'b0;
        kp_gain = 4915; kd_gain = 1229; lin_limit = 32768; ang_limit = 65536;
        ofs_fwd = 0; ofs_lat = 0; err_x_prev = 0; err_y_prev = 0;
        zero_cmd = '0;
        none = '0;

        // Directed table: reset defaults, invalid flags, extremes, heading folding.
        rows.insert(rows.size(), t_row'{make_tick(0, 0, 0, 0, 0, 0, 1, 1), ROW_TYPED,
                                        zero_cmd});
        rows.insert(rows.size(), t_row'{make_tick(5, 6, 7, 8, 9, 10, 0, 1), ROW_SILENT,
                                        none});
        rows.insert(rows.size(), t_row'{make_tick(5, 6, 7, 8, 9, 10, 1, 0), ROW_SILENT,
                                        none});
        rows.insert(rows.size(), t_row'{make_tick(-1, -1, -1, -1, -1, -1, 0, 0),
                                        ROW_SILENT, none});
        rows.insert(rows.size(), t_row'{make_tick(32'h80000000, 32'h80000000, 0,
                                        32'h7FFFFFFF, 32'h7FFFFFFF, 0, 1, 1),
                                        ROW_PREDICT, none});
        rows.insert(rows.size(), t_row'{make_tick(32'h7FFFFFFF, 32'h7FFFFFFF, 25736,
                                        32'h80000000, 32'h80000000, -25736, 1, 1),
                                        ROW_PREDICT, none});
        rows.insert(rows.size(), t_row'{make_tick(65536, -65536, 32767, 0, 0, -32768,
                                        1, 1), ROW_PREDICT, none});
        rows.insert(rows.size(), t_row'{make_tick(0, 0, -32768, 131072, 65536, 32767,
                                        1, 1), ROW_PREDICT, none});
        rows.insert(rows.size(), t_row'{make_tick(0, 0, 12868, 65536, 0, 12868, 1, 1),
                                        ROW_PREDICT, none});
        rows.insert(rows.size(), t_row'{make_tick(0, 0, -12869, 0, 65536, -12869, 1, 1),
                                        ROW_PREDICT, none});
        rows.insert(rows.size(), t_row'{make_tick(1000, 2000, 100, 1000, 2000, 100, 1, 1),
                                        ROW_PREDICT, none});

        // Phase settings: gain P, gain D, speed limit, turn limit, forward, lateral.
        phase_cfg[0] = '{32'd4915, 32'd1229, 32'd32768, 32'd65536, 32'd0, 32'd0};
        phase_cfg[1] = '{32'hFFFF, 32'hFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                         32'h7FFFFFFF, 32'h80000000};
        phase_cfg[2] = '{32'd0, 32'd0, 32'd0, 32'd0, 32'h80000000, 32'h7FFFFFFF};
        phase_cfg[3] = '{32'd8192, 32'd2048, 32'd131072, 32'd98304,
                         32'hFFFE0000, 32'd65536};
        phase_cfg[4] = '{32'hFFFF, 32'd0, 32'hFFFFFFFF, 32'd1, 32'd0, 32'hFFFF0000};
        phase_cfg[5] = '{32'd1, 32'hFFFF, 32'd1, 32'h7FFFFFFF, 32'd65536, 32'd0};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) send_tick(rows[k].tick, rows[k].kind, rows[k].want);
        drain();

        for (int p = 0; p < 6; p++) begin
            set_config(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                       phase_cfg[p][3], phase_cfg[p][4], phase_cfg[p][5]);
            // Writes beyond the last register must leave the settings alone.
            if (p == 1) cfg_write(REG_UNUSED, 32'hFFFFFFFF);
            if (p == 2) long_hold_req = 1'b1;
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                quiet = (n >= 60 && n < 90);
                if (p == 1 && n < 4) send_tick(rows[4 + n].tick, ROW_PREDICT, none);
                else send_tick(random_tick(), ROW_PREDICT, none);
            end
            quiet = 1'b0;
            drain();
        end

        if (fail_count == 0) begin
            $display("formation_pd_follower_top regression: pass");
        end else begin
            $display("formation_pd_follower_top regression: fail");
        end
        $finish;
    end

endmodule
